// ===== hdl/spfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere product field evaluator package
// Op codes, sphere entry type and fixed-point constants shared by the core.
// ----------------------------------------------------------------------------
package spfe_pkg;

    localparam int SPFE_MAX_SPHERES = 64;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam int FV_W = 48;

    localparam logic signed [FV_W-1:0] ONE_Q16 = 48'sh0000_0001_0000;
    localparam logic [FV_W-1:0]        FV_POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [FV_W-1:0]        FV_NEG_LIM = 48'h8000_0000_0000;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic [14:0]        r;
    } t_sphere;

endpackage
`default_nettype wire

// ===== hdl/sphere_product_field_evaluator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere product field evaluator core
// Sphere table with add/clear and a query that multiplies the blend terms of
// all spheres whose bounding cube holds the point, using one shared multiplier.
// ----------------------------------------------------------------------------
// Add, clear and no-op words are taken while idle; their result word shows
// on the next cycle and busy stays low. A query holds busy while it steps
// through the stored spheres; for each sphere whose bounding cube holds the
// point, four squares and two partial products go through the single 24x32
// multiplier, then one normalize step. The result is valid for
// exactly one cycle on o_valid and must be taken then.
module sphere_product_field_evaluator_core
    import spfe_pkg::*;
#(
    parameter int MAX_SPHERES = SPFE_MAX_SPHERES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_op,
    input  wire logic signed [15:0]   i_pos_x,
    input  wire logic signed [15:0]   i_pos_y,
    input  wire logic signed [15:0]   i_pos_z,
    input  wire logic [14:0]          i_radius,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic signed [47:0]   i_cfg_wr_data,
    output logic                      o_valid,
    output logic signed [47:0]        o_field_value,
    output logic                      o_inside_res,
    output logic                      o_saturated,
    output logic                      o_status
);

    localparam int CNT_W = $clog2(MAX_SPHERES + 1);
    localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_SIGN = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_NORM = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    t_sphere r_mem [MAX_SPHERES];
    t_sphere r_rd_data;

    logic [2:0]               r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [1:0]               r_k, n_k;
    logic signed [47:0]       r_thr;
    logic                     r_valid, n_valid;
    logic signed [47:0]       r_field, n_field;
    logic                     r_inside, n_inside;
    logic                     r_sat_out, n_sat_out;
    logic                     r_status, n_status;

    logic signed [15:0]       r_px, n_px;
    logic signed [15:0]       r_py, n_py;
    logic signed [15:0]       r_pz, n_pz;
    logic [14:0]              r_dx, n_dx;
    logic [14:0]              r_dy, n_dy;
    logic [14:0]              r_dz, n_dz;
    logic [14:0]              r_rr, n_rr;
    logic signed [33:0]       r_term, n_term;
    logic signed [47:0]       r_acc, n_acc;
    logic                     r_sat, n_sat;
    logic [47:0]              r_amag, n_amag;
    logic [31:0]              r_tmag, n_tmag;
    logic                     r_neg, n_neg;
    logic [79:0]              r_prod, n_prod;

    logic                     w_accept;
    logic                     w_mem_we;
    t_sphere                  w_wr_entry;
    logic [23:0]              w_mul_a;
    logic [31:0]              w_mul_b;
    logic [55:0]              w_mul_p;
    logic [14:0]              w_sq_op;
    logic signed [16:0]       w_ddx, w_ddy, w_ddz;
    logic [15:0]              w_adx, w_ady, w_adz;
    logic                     w_in_cube;
    logic signed [33:0]       w_term_neg;
    logic signed [47:0]       w_acc_neg;
    logic [63:0]              w_q;
    logic [47:0]              w_lim;
    logic                     w_q_sat;
    logic [47:0]              w_qc;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_wr_entry = '{cx: i_pos_x, cy: i_pos_y, cz: i_pos_z, r: i_radius};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= w_wr_entry;
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_comb begin
        case (r_k)
            2'd0:    w_sq_op = r_dx;
            2'd1:    w_sq_op = r_dy;
            2'd2:    w_sq_op = r_dz;
            default: w_sq_op = r_rr;
        endcase
    end

    assign w_mul_a = (r_state == S_MUL) ? (r_k[0] ? r_amag[47:24] : r_amag[23:0])
                                        : {9'b0, w_sq_op};
    assign w_mul_b = (r_state == S_MUL) ? r_tmag : {17'b0, w_sq_op};
    assign w_mul_p = 56'(w_mul_a) * 56'(w_mul_b);

    assign w_ddx = {r_px[15], r_px} - {r_rd_data.cx[15], r_rd_data.cx};
    assign w_ddy = {r_py[15], r_py} - {r_rd_data.cy[15], r_rd_data.cy};
    assign w_ddz = {r_pz[15], r_pz} - {r_rd_data.cz[15], r_rd_data.cz};
    assign w_adx = w_ddx[16] ? 16'(-w_ddx) : w_ddx[15:0];
    assign w_ady = w_ddy[16] ? 16'(-w_ddy) : w_ddy[15:0];
    assign w_adz = w_ddz[16] ? 16'(-w_ddz) : w_ddz[15:0];
    assign w_in_cube = (w_adx <= {1'b0, r_rd_data.r}) && (w_ady <= {1'b0, r_rd_data.r})
                    && (w_adz <= {1'b0, r_rd_data.r});

    assign w_term_neg = -r_term;
    assign w_acc_neg  = -r_acc;

    assign w_q     = r_prod[79:16];
    assign w_lim   = r_neg ? FV_NEG_LIM : FV_POS_LIM;
    assign w_q_sat = (|w_q[63:48]) || (w_q[47:0] > w_lim);
    assign w_qc    = w_q_sat ? w_lim : w_q[47:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_k       = r_k;
        n_valid   = 1'b0;
        n_field   = r_field;
        n_inside  = r_inside;
        n_sat_out = r_sat_out;
        n_status  = r_status;
        n_px      = r_px;
        n_py      = r_py;
        n_pz      = r_pz;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_dz      = r_dz;
        n_rr      = r_rr;
        n_term    = r_term;
        n_acc     = r_acc;
        n_sat     = r_sat;
        n_amag    = r_amag;
        n_tmag    = r_tmag;
        n_neg     = r_neg;
        n_prod    = r_prod;
        w_mem_we  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_field   = '0;
                    n_inside  = 1'b0;
                    n_sat_out = 1'b0;
                    n_status  = 1'b0;
                    case (i_op)
                        OP_ADD: begin
                            n_valid = 1'b1;
                            if (r_count >= CNT_W'(MAX_SPHERES)) begin
                                n_status = 1'b1;
                            end else begin
                                w_mem_we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            n_px    = i_pos_x;
                            n_py    = i_pos_y;
                            n_pz    = i_pos_z;
                            n_acc   = ONE_Q16;
                            n_sat   = 1'b0;
                            n_idx   = '0;
                            n_state = S_READ;
                        end
                        OP_CLEAR: begin
                            n_valid = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = (r_idx == r_count) ? S_DONE : S_DIFF;
            end
            S_DIFF: begin
                if (w_in_cube) begin
                    n_dx    = w_adx[14:0];
                    n_dy    = w_ady[14:0];
                    n_dz    = w_adz[14:0];
                    n_rr    = r_rd_data.r;
                    n_term  = '0;
                    n_k     = '0;
                    n_state = S_SQ;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_READ;
                end
            end
            S_SQ: begin
                if (r_k == 2'd3) begin
                    n_term  = r_term - 34'(w_mul_p[29:0]);
                    n_state = S_SIGN;
                end else begin
                    n_term  = r_term + 34'(w_mul_p[29:0]);
                end
                n_k = r_k + 2'd1;
            end
            S_SIGN: begin
                n_tmag  = r_term[33] ? w_term_neg[31:0] : r_term[31:0];
                n_amag  = r_acc[47] ? w_acc_neg : r_acc;
                n_neg   = r_acc[47] ^ r_term[33];
                n_k     = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_k == 2'd0) begin
                    n_prod = {24'b0, w_mul_p};
                    n_k    = 2'd1;
                end else begin
                    n_prod  = r_prod + {w_mul_p, 24'b0};
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_acc   = r_neg ? -$signed(w_qc) : $signed(w_qc);
                n_sat   = r_sat | w_q_sat;
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_READ;
            end
            S_DONE: begin
                n_valid   = 1'b1;
                n_field   = r_acc;
                n_inside  = (r_acc <= r_thr);
                n_sat_out = r_sat;
                n_status  = 1'b0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_k     <= '0;
            r_valid <= 1'b0;
            r_thr   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_k     <= n_k;
            r_valid <= n_valid;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_field   <= n_field;
        r_inside  <= n_inside;
        r_sat_out <= n_sat_out;
        r_status  <= n_status;
        r_px      <= n_px;
        r_py      <= n_py;
        r_pz      <= n_pz;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_dz      <= n_dz;
        r_rr      <= n_rr;
        r_term    <= n_term;
        r_acc     <= n_acc;
        r_sat     <= n_sat;
        r_amag    <= n_amag;
        r_tmag    <= n_tmag;
        r_neg     <= n_neg;
        r_prod    <= n_prod;
    end

    assign o_valid       = r_valid;
    assign o_field_value = r_field;
    assign o_inside_res  = r_inside;
    assign o_saturated   = r_sat_out;
    assign o_status      = r_status;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPHERES))
        else $error("sphere count above table depth");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_QUERY) |=> busy)
        else $error("query word did not raise busy");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_DONE) || $past(start && r_state == S_IDLE))
        else $error("result word without a source");

    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_field_value == '0 && !o_saturated && !o_inside_res))
        else $error("dropped add carries field data");

    a_mul_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_k <= 2'd1))
        else $error("partial product step out of range");

endmodule
`default_nettype wire

// ===== tb/sv/tb_sphere_product_field_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// Sphere product field evaluator core testbench
// Sends add, query, clear and no-op words in random bursts and checks each
// result word against a local model of the sphere table and the saturating
// Q31.16 product, across several inside thresholds.
// ----------------------------------------------------------------------------
module tb_sphere_product_field_evaluator_core;
    import spfe_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int WORDS_PER_PHASE = 376;

    typedef struct {
        logic [1:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [14:0]        r;
    } t_sphere_word;

    typedef struct packed {
        logic signed [47:0] field_value;
        logic               inside_res;
        logic               saturated;
        logic               status;
    } t_field_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_op = OP_NOP;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic signed [15:0] i_pos_z = '0;
    logic [14:0]        i_radius = '0;
    logic               i_cfg_wr_en = 1'b0;
    logic signed [47:0] i_cfg_wr_data = '0;
    logic               o_valid;
    logic signed [47:0] o_field_value;
    logic               o_inside_res;
    logic               o_saturated;
    logic               o_status;

    t_sphere_word  pending_words[$];
    t_field_result expected_fields[$];

    t_sphere            sphere_table[SPFE_MAX_SPHERES];
    int                 sphere_count;
    logic signed [47:0] fv_threshold;

    int words_queued;
    int mismatches;
    int idle_cycles;
    int n_results, n_queries, n_sat, n_inside, n_adds, n_dropped, n_clears;
    int n_thresholds;
    int burst_left;
    int gap_left;

    sphere_product_field_evaluator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_radius      (i_radius),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .o_field_value (o_field_value),
        .o_inside_res  (o_inside_res),
        .o_saturated   (o_saturated),
        .o_status      (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic logic signed [47:0] blend_mul_q16(input logic signed [47:0] acc,
                                                        input longint term,
                                                        inout bit sat);
        logic [47:0] mag_a;
        logic [47:0] mag_b;
        logic [95:0] prod;
        logic [95:0] lim;
        bit          neg;
        neg = (acc < 0) != (term < 0);
        mag_a = (acc < 0) ? -acc : acc;
        mag_b = 48'((term < 0) ? -term : term);
        prod = mag_a * mag_b;
        prod = prod >> 16;
        lim = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
        if (prod > lim) begin
            sat = 1'b1;
            prod = lim;
        end
        return neg ? -prod[47:0] : prod[47:0];
    endfunction

    function automatic t_field_result evaluate_word(input t_sphere_word w);
        t_field_result      res;
        logic signed [47:0] acc;
        bit                 sat;
        int                 dx, dy, dz, rr, k;
        longint             term;
        res = '0;
        case (w.op)
            OP_ADD: begin
                n_adds++;
                if (sphere_count >= SPFE_MAX_SPHERES) begin
                    res.status = 1'b1;
                    n_dropped++;
                end else begin
                    sphere_table[sphere_count] = '{cx: w.x, cy: w.y, cz: w.z, r: w.r};
                    sphere_count++;
                end
            end
            OP_QUERY: begin
                n_queries++;
                acc = ONE_Q16;
                sat = 1'b0;
                for (k = 0; k < sphere_count; k++) begin
                    dx = w.x - sphere_table[k].cx;
                    dy = w.y - sphere_table[k].cy;
                    dz = w.z - sphere_table[k].cz;
                    rr = sphere_table[k].r;
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    if (dz < 0) dz = -dz;
                    if (dx <= rr && dy <= rr && dz <= rr) begin
                        term = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz
                             - longint'(rr) * rr;
                        acc = blend_mul_q16(acc, term, sat);
                    end
                end
                res.field_value = acc;
                res.inside_res = (acc <= fv_threshold);
                res.saturated = sat;
                n_sat += sat;
                n_inside += res.inside_res;
            end
            OP_CLEAR: begin
                n_clears++;
                sphere_count = 0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int rand_coord();
        logic signed [15:0] v;
        v = 16'($urandom);
        return v;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int near_coord(input int c, input int r);
        return clamp_coord(c + int'($urandom_range(0, 2 * r + 2)) - (r + 1));
    endfunction

    task automatic queue_word(input logic [1:0] op, input int x, input int y, input int z,
                              input int r);
        t_sphere_word w;
        w.op = op;
        w.x = 16'(x);
        w.y = 16'(y);
        w.z = 16'(z);
        w.r = 15'(r);
        pending_words = {pending_words, w};
        if (op != OP_NOP) words_queued++;
    endtask

    task automatic queue_scene(input bit big);
        int  cx[$], cy[$], cz[$], cr[$];
        int  n, nq, k, pick, idx, r;
        int  bx, by, bz;
        bit  cluster;
        n = big ? $urandom_range(64, 70) : $urandom_range(0, 8);
        nq = big ? 3 : $urandom_range(2, 12);
        cluster = ($urandom_range(0, 2) == 0);
        bx = rand_coord();
        by = rand_coord();
        bz = rand_coord();
        if ($urandom_range(0, 9) != 0)
            queue_word(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), $urandom);
        for (k = 0; k < n; k++) begin
            if (cluster) begin
                r = $urandom_range(0, 1) ? $urandom_range(4096, 32767) : $urandom_range(0, 300);
                cx = {cx, near_coord(bx, 512)};
                cy = {cy, near_coord(by, 512)};
                cz = {cz, near_coord(bz, 512)};
            end else begin
                r = $urandom_range(0, 2) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
                cx = {cx, rand_coord()};
                cy = {cy, rand_coord()};
                cz = {cz, rand_coord()};
            end
            cr = {cr, r};
            queue_word(OP_ADD, cx[k], cy[k], cz[k], r);
            if ($urandom_range(0, 19) == 0)
                queue_word(OP_NOP, rand_coord(), rand_coord(), rand_coord(), $urandom);
        end
        for (k = 0; k < nq; k++) begin
            pick = $urandom_range(0, 9);
            if (n == 0 || pick >= 8) begin
                queue_word(OP_QUERY, rand_coord(), rand_coord(), rand_coord(), $urandom);
            end else begin
                idx = $urandom_range(0, n - 1);
                if (pick == 7)
                    queue_word(OP_QUERY, cx[idx], cy[idx], cz[idx], $urandom);
                else if (pick == 6 && cluster)
                    queue_word(OP_QUERY, near_coord(bx, 256), near_coord(by, 256),
                               near_coord(bz, 256), $urandom);
                else
                    queue_word(OP_QUERY, near_coord(cx[idx], cr[idx]),
                               near_coord(cy[idx], cr[idx]), near_coord(cz[idx], cr[idx]),
                               $urandom);
            end
            if ($urandom_range(0, 15) == 0)
                queue_word($urandom_range(0, 1) ? OP_NOP : OP_ADD, rand_coord(), rand_coord(),
                           rand_coord(), $urandom);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || start || expected_fields.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic signed [47:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        n_thresholds++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_sphere_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left <= 1;
            gap_left <= 0;
        end else if (!start || !busy) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                i_op <= w.op;
                i_pos_x <= w.x;
                i_pos_y <= w.y;
                i_pos_z <= w.z;
                i_radius <= w.r;
                start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                               : $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sphere_word  w;
        t_field_result want;
        if (!i_rst_n) begin
            sphere_count = 0;
            fv_threshold = '0;
            idle_cycles = 0;
        end else begin
            if (o_valid) begin
                n_results++;
                if (expected_fields.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_fields.pop_front();
                    if (o_field_value !== want.field_value)
                        report_mismatch($sformatf("field_value got %0d want %0d",
                                                  o_field_value, want.field_value));
                    if (o_inside_res !== want.inside_res)
                        report_mismatch($sformatf("inside_res got %b want %b",
                                                  o_inside_res, want.inside_res));
                    if (o_saturated !== want.saturated)
                        report_mismatch($sformatf("saturated got %b want %b",
                                                  o_saturated, want.saturated));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status got %b want %b",
                                                  o_status, want.status));
                end
            end
            if (i_cfg_wr_en) fv_threshold = i_cfg_wr_data;
            if (start && !busy) begin
                w.op = i_op;
                w.x = i_pos_x;
                w.y = i_pos_y;
                w.z = i_pos_z;
                w.r = i_radius;
                expected_fields = {expected_fields, evaluate_word(w)};
            end
            if (o_valid || (start && !busy)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL sphere_product_field_evaluator_core");
                $finish;
            end
        end
    end

    initial begin
        logic signed [47:0] thr;
        int                 ph, phase_end;
        bit                 first;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_word(OP_QUERY, 0, 0, 0, 0);
        queue_word(OP_NOP, -32768, 32767, -1, 32767);
        queue_word(OP_ADD, 0, 0, 0, 256);
        queue_word(OP_QUERY, 0, 0, 0, 0);
        queue_word(OP_QUERY, 256, 256, 256, 32767);
        queue_word(OP_QUERY, 257, 0, 0, 0);
        queue_word(OP_ADD, 32767, -32768, 32767, 32767);
        queue_word(OP_ADD, -32768, 32767, -32768, 0);
        queue_word(OP_QUERY, -32768, 32767, -32768, 0);
        queue_word(OP_QUERY, 0, -1, 32767, 0);
        queue_word(OP_CLEAR, -1, -1, -1, 32767);
        queue_word(OP_QUERY, 100, -100, 5, 0);
        repeat (3) queue_word(OP_ADD, 0, 0, 0, 32767);
        queue_word(OP_QUERY, 32767, 32767, 32767, 0);
        queue_word(OP_ADD, 32767, 32767, 32767, 32767);
        queue_word(OP_QUERY, 32767, 32767, 32767, 0);
        queue_word(OP_QUERY, -32768, -32768, -32768, 0);
        queue_word(OP_NOP, 0, 0, 0, 0);
        queue_word(OP_CLEAR, 0, 0, 0, 0);
        wait_idle();

        first = 1'b1;
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: thr = 48'sh8000_0000_0000;
                1: thr = 48'sh7FFF_FFFF_FFFF;
                2: thr = ONE_Q16;
                3: thr = 48'({$urandom, $urandom});
                default: thr = $signed(21'($urandom));
            endcase
            write_threshold(thr);
            phase_end = words_queued + WORDS_PER_PHASE;
            while (words_queued < phase_end) begin
                queue_scene(first || $urandom_range(0, 14) == 0);
                first = 1'b0;
            end
            wait_idle();
        end
        repeat (20) @(posedge i_clk);

        $display("covered %0d result words: %0d queries (%0d saturated, %0d inside),",
                 n_results, n_queries, n_sat, n_inside);
        $display("%0d adds (%0d dropped on a full table), %0d clears, %0d thresholds",
                 n_adds, n_dropped, n_clears, n_thresholds + 1);
        if (mismatches == 0 && expected_fields.size() == 0) begin
            $display("PASS sphere_product_field_evaluator_core");
        end else begin
            $display("FAIL sphere_product_field_evaluator_core");
        end
        $finish;
    end

endmodule
